### sv/qmr_pkg.sv
// Shared widths, codes and transfer payload types of the quaternion unit.
package qmr_pkg;

   localparam int DW = 16;            // width of every data field
   localparam int PW = 2 * DW;        // width of one component product
   localparam int MW = 2 * DW + 2;    // width of a four-product sum or matrix entry
   localparam int NW = 2 * DW + 1;    // width of the squared norm
   localparam int SW = 3 * DW + 3;    // width of a rotation numerator

   localparam logic MODE_MUL = 1'b0;
   localparam logic MODE_ROT = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic signed [DW-1:0] a_w;
      logic signed [DW-1:0] a_x;
      logic signed [DW-1:0] a_y;
      logic signed [DW-1:0] a_z;
      logic signed [DW-1:0] b_w;
      logic signed [DW-1:0] b_x;
      logic signed [DW-1:0] b_y;
      logic signed [DW-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] r_w;
      logic signed [DW-1:0] r_x;
      logic signed [DW-1:0] r_y;
      logic signed [DW-1:0] r_z;
      logic                 overflow;
      logic                 div_zero;
   } rsp_type;

endpackage

### sv/qmr_div.sv
// Pipelined restoring divider with rounding and saturation for one rotated component.
module qmr_div (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [qmr_pkg::SW-1:0] num,
   input  logic        [qmr_pkg::NW-1:0] den,
   output logic signed [qmr_pkg::DW-1:0] quot,
   output logic                          ovf
);

   localparam int DW = qmr_pkg::DW;
   localparam int SW = qmr_pkg::SW;
   localparam int NW = qmr_pkg::NW;
   localparam int RW = SW - 1;

   logic [RW-1:0] rem_ff [DW+2];
   logic [DW:0]   q_ff   [DW+2];
   logic [NW-1:0] den_ff [DW+2];
   logic          neg_ff [DW+2];
   logic          big_ff [DW+2];

   logic [RW-1:0] mag_in;
   logic          big_in;

   logic signed [DW-1:0] quot_ff, quot_in;
   logic                 ovf_ff, ovf_in;

   always_comb begin
      mag_in = num[SW-1] ? RW'(-num) : RW'(num);
      // Any quotient at or above 2^(DW+1) saturates, so those bits are never formed.
      big_in = mag_in >= (RW'(den) << (DW + 1));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= mag_in;
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= num[SW-1];
         big_ff[0] <= big_in;
      end
   end

   for (genvar i = 0; i <= DW; i++) begin : g_step
      logic [RW-1:0] d_w;
      logic          ge_w;
      assign d_w  = RW'(den_ff[i]) << (DW - i);
      assign ge_w = rem_ff[i] >= d_w;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i+1] <= ge_w ? rem_ff[i] - d_w : rem_ff[i];
            q_ff[i+1]   <= q_ff[i] | ((DW+1)'(ge_w) << (DW - i));
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            big_ff[i+1] <= big_ff[i];
         end
      end
   end

   always_comb begin
      logic          up;
      logic [DW+1:0] qr;
      logic [DW+1:0] lim;
      logic [DW+1:0] m;
      logic          sat;
      up  = {rem_ff[DW+1][NW-1:0], 1'b0} >= {1'b0, den_ff[DW+1]};
      qr  = (DW+2)'(q_ff[DW+1]) + (DW+2)'(up);
      lim = neg_ff[DW+1] ? ((DW+2)'(1) << (DW - 1)) : ((DW+2)'(1) << (DW - 1)) - 1'b1;
      sat = big_ff[DW+1] || (qr > lim);
      m   = sat ? lim : qr;
      quot_in = neg_ff[DW+1] ? -m[DW-1:0] : m[DW-1:0];
      ovf_in  = sat;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= quot_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign quot = quot_ff;
   assign ovf  = ovf_ff;

endmodule

### sv/quaternion_multiply_and_rotate.sv
// Top level of the pipelined quaternion multiply and vector rotate unit.
// Takes one transfer per clock while the result side is not stalled and returns one
// result per transfer, in order; the rotation divider forms one quotient bit per
// pipeline stage. A stall on the result side holds the whole pipeline and raises
// req_stall in the same cycle; nothing is lost or repeated.
module quaternion_multiply_and_rotate #(
   parameter int FRAC_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qmr_pkg::rsp_type rsp_data
);

   localparam int DW = qmr_pkg::DW;
   localparam int PW = qmr_pkg::PW;
   localparam int MW = qmr_pkg::MW;
   localparam int NW = qmr_pkg::NW;
   localparam int SW = qmr_pkg::SW;
   localparam int L  = DW + 3;

   typedef struct packed {
      logic                  valid;
      logic                  mode;
      logic                  dz;
      logic [3:0][DW-1:0]    r0;
      logic                  ovf0;
   } side_type;

   logic rsp_valid_ff;
   logic advance;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: all component products.
   logic signed [DW-1:0] a_w [4];
   logic signed [DW-1:0] b_w [4];
   logic signed [PW-1:0] cr_in [4][4];
   logic signed [PW-1:0] cr_ff [4][4];
   logic signed [PW-1:0] sq_in [4];
   logic signed [PW-1:0] sq_ff [4];
   logic signed [PW-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [DW-1:0] bv1_ff [3];
   logic                 v1_ff, mode1_ff;

   always_comb begin
      a_w[0] = req_data.a_w;  a_w[1] = req_data.a_x;
      a_w[2] = req_data.a_y;  a_w[3] = req_data.a_z;
      b_w[0] = req_data.b_w;  b_w[1] = req_data.b_x;
      b_w[2] = req_data.b_y;  b_w[3] = req_data.b_z;
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = a_w[i] * a_w[i];
         for (int j = 0; j < 4; j++) begin
            cr_in[i][j] = a_w[i] * b_w[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode1_ff <= req_data.mode;
         cr_ff    <= cr_in;
         sq_ff    <= sq_in;
         xy_ff    <= a_w[1] * a_w[2];
         xz_ff    <= a_w[1] * a_w[3];
         yz_ff    <= a_w[2] * a_w[3];
         wx_ff    <= a_w[0] * a_w[1];
         wy_ff    <= a_w[0] * a_w[2];
         wz_ff    <= a_w[0] * a_w[3];
         bv1_ff[0] <= req_data.b_x;
         bv1_ff[1] <= req_data.b_y;
         bv1_ff[2] <= req_data.b_z;
      end
   end

   // Stage 2: Hamilton sums, squared norm and the unnormalized rotation matrix.
   logic signed [MW-1:0] qs2_ff [4];
   logic signed [MW-1:0] m2_ff [3][3];
   logic        [NW-1:0] n2_ff;
   logic signed [DW-1:0] bv2_ff [3];
   logic                 v2_ff, mode2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode2_ff <= mode1_ff;
         bv2_ff   <= bv1_ff;
         qs2_ff[0] <= MW'(cr_ff[0][0]) - MW'(cr_ff[1][1]) - MW'(cr_ff[2][2])
                      - MW'(cr_ff[3][3]);
         qs2_ff[1] <= MW'(cr_ff[0][1]) + MW'(cr_ff[1][0]) + MW'(cr_ff[2][3])
                      - MW'(cr_ff[3][2]);
         qs2_ff[2] <= MW'(cr_ff[0][2]) - MW'(cr_ff[1][3]) + MW'(cr_ff[2][0])
                      + MW'(cr_ff[3][1]);
         qs2_ff[3] <= MW'(cr_ff[0][3]) + MW'(cr_ff[1][2]) - MW'(cr_ff[2][1])
                      + MW'(cr_ff[3][0]);
         n2_ff <= NW'($unsigned(sq_ff[0])) + NW'($unsigned(sq_ff[1]))
                  + NW'($unsigned(sq_ff[2])) + NW'($unsigned(sq_ff[3]));
         m2_ff[0][0] <= MW'(sq_ff[0]) + MW'(sq_ff[1]) - MW'(sq_ff[2]) - MW'(sq_ff[3]);
         m2_ff[0][1] <= (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
         m2_ff[0][2] <= (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
         m2_ff[1][0] <= (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
         m2_ff[1][1] <= MW'(sq_ff[0]) - MW'(sq_ff[1]) + MW'(sq_ff[2]) - MW'(sq_ff[3]);
         m2_ff[1][2] <= (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
         m2_ff[2][0] <= (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
         m2_ff[2][1] <= (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
         m2_ff[2][2] <= MW'(sq_ff[0]) - MW'(sq_ff[1]) - MW'(sq_ff[2]) + MW'(sq_ff[3]);
      end
   end

   // Stage 3: matrix times vector, and rounding of the Hamilton product.
   logic signed [SW-1:0] pr3_ff [3][3];
   logic        [NW-1:0] n3_ff;
   logic                 dz3_ff;
   logic [3:0][DW-1:0]   r03_in, r03_ff;
   logic                 ovf03_in, ovf03_ff;
   logic                 v3_ff, mode3_ff;

   always_comb begin
      logic          neg;
      logic [MW-1:0] mag;
      logic [MW:0]   sh;
      logic [MW:0]   lim;
      logic [MW:0]   m;
      ovf03_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         neg = qs2_ff[k][MW-1];
         mag = neg ? MW'(-qs2_ff[k]) : MW'(qs2_ff[k]);
         sh  = ({1'b0, mag} + ((MW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         lim = neg ? ((MW+1)'(1) << (DW - 1)) : ((MW+1)'(1) << (DW - 1)) - 1'b1;
         m   = (sh > lim) ? lim : sh;
         if (sh > lim) begin
            ovf03_in = 1'b1;
         end
         r03_in[k] = neg ? -m[DW-1:0] : m[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode3_ff <= mode2_ff;
         n3_ff    <= n2_ff;
         dz3_ff   <= n2_ff == '0;
         r03_ff   <= r03_in;
         ovf03_ff <= ovf03_in;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pr3_ff[i][j] <= SW'(m2_ff[i][j]) * SW'(bv2_ff[j]);
            end
         end
      end
   end

   // Stage 4: rotation numerators.
   logic signed [SW-1:0] s4_ff [3];
   logic        [NW-1:0] n4_ff;
   side_type             side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff.valid <= 1'b0;
      end else if (advance) begin
         side4_ff.valid <= v3_ff;
      end
      if (advance) begin
         side4_ff.mode <= mode3_ff;
         side4_ff.dz   <= dz3_ff;
         side4_ff.r0   <= r03_ff;
         side4_ff.ovf0 <= ovf03_ff;
         n4_ff         <= n3_ff;
         for (int i = 0; i < 3; i++) begin
            s4_ff[i] <= pr3_ff[i][0] + pr3_ff[i][1] + pr3_ff[i][2];
         end
      end
   end

   // Dividers, with the remaining fields delayed alongside.
   logic signed [DW-1:0] quot_w [3];
   logic                 ovf_w  [3];

   for (genvar k = 0; k < 3; k++) begin : g_div
      qmr_div u_div (
         .clock  (clock),
         .enable (advance),
         .num    (s4_ff[k]),
         .den    (n4_ff),
         .quot   (quot_w[k]),
         .ovf    (ovf_w[k])
      );
   end

   side_type side_ff [L];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0] <= side4_ff;
         for (int k = 1; k < L; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Output register.
   qmr_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in = '0;
      if (side_ff[L-1].mode == qmr_pkg::MODE_MUL) begin
         rsp_in.r_w      = side_ff[L-1].r0[0];
         rsp_in.r_x      = side_ff[L-1].r0[1];
         rsp_in.r_y      = side_ff[L-1].r0[2];
         rsp_in.r_z      = side_ff[L-1].r0[3];
         rsp_in.overflow = side_ff[L-1].ovf0;
      end else if (side_ff[L-1].dz) begin
         rsp_in.div_zero = 1'b1;
      end else begin
         rsp_in.r_x      = quot_w[0];
         rsp_in.r_y      = quot_w[1];
         rsp_in.r_z      = quot_w[2];
         rsp_in.overflow = ovf_w[0] | ovf_w[1] | ovf_w[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= side_ff[L-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A held result must freeze the pipeline in the same cycle.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("pipeline advanced while a result was held");

   // An accepted transfer must occupy the first stage on the next edge.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted transfer did not enter the pipeline");

   // A zero-norm rotation returns zeros and no overflow.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |->
         !rsp_data.overflow && rsp_data.r_w == '0 && rsp_data.r_x == '0
         && rsp_data.r_y == '0 && rsp_data.r_z == '0)
      else $error("zero-norm result not cleared");

   // A result that is not taken moves the last pipeline stage nowhere.
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(side_ff[L-1].valid))
      else $error("tail stage moved during a stall");

endmodule
